@@ design/pss_pkg.sv @@
// Shared types and constants for the periodic slot scheduler.
// Used by the channel interfaces and by every scheduler module; depends on nothing.
package pss_pkg;

  // Table size and result limits.
  localparam int SLOTS       = 32;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths of the request and result channels.
  localparam int NOW_W     = 32;
  localparam int RATE_W    = 10;
  localparam int KIND_W    = 2;
  localparam int OUT_IDX_W = 5;

  // Period arithmetic: period = RATE_NUMERATOR / rate, which fits in PER_W bits.
  localparam int PER_W          = 10;
  localparam int RATE_NUMERATOR = 1000;
  localparam int STEP_W         = $clog2(PER_W + 1);

  // Request opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_DIV,
    S_ADD_REPLY,
    S_ADD_FULL,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_END
  } pss_state_t;

  // Selects what the output register is loaded with.
  typedef enum logic [1:0] {
    EMIT_ADD_OK,
    EMIT_ADD_FULL,
    EMIT_PEND,
    EMIT_IDLE
  } pss_emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      idx_clr;
    logic      idx_inc;
    logic      div_start;
    logic      mem_rd;
    logic      add_wr;
    logic      fire_wr;
    logic      pend_clr;
    logic      pend_cap;
    logic      emit;
    pss_emit_t emit_sel;
    logic      emit_last;
  } pss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic slot_act;
    logic slot_hit;
    logic div_done;
    logic out_free;
    logic pend_valid;
    logic cap_ok;
  } pss_sts_t;

endpackage

@@ design/pss_ifs.sv @@
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on pss_pkg for the field widths.
interface pss_in_if import pss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [NOW_W-1:0]  now_ms;
  logic [RATE_W-1:0] rate_per_second;

  modport source (output valid, output opcode, output now_ms, output rate_per_second,
                  input ready);
  modport sink   (input valid, input opcode, input now_ms, input rate_per_second,
                  output ready);
endinterface

interface pss_out_if import pss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [OUT_IDX_W-1:0] slot_index;
  logic                 table_full;
  logic                 last;

  modport source (output valid, output kind, output slot_index, output table_full,
                  output last, input ready);
  modport sink   (input valid, input kind, input slot_index, input table_full,
                  input last, output ready);
endinterface

@@ design/periodic_slot_scheduler.sv @@
// Periodic slot scheduler: one request at a time over a table of SLOTS slots, with a
// registered result output. An add request scans the active bits one slot a cycle for
// the lowest free slot while a bit-serial divider forms the period (1000 / rate).
// A tick request walks every slot through the registered read of the due time memory,
// stalling on a firing slot while the result sink holds the output register.
// Every firing slot gives a result marked last only on the final one; a tick with no
// firing gives one nothing-fired result. A new request is taken once the previous one
// has placed its final result in the output register.
// Depends on pss_pkg, pss_ifs, pss_div, pss_datapath and pss_ctrl.
module periodic_slot_scheduler import pss_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  pss_in_if.sink  in_req,
  pss_out_if.source out_rsp
);

  pss_cmd_t cmd;
  pss_sts_t sts;
  logic     req_ready;

  // Controller.
  pss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid_i  (in_req.valid),
    .req_opcode_i (in_req.opcode),
    .req_ready_o  (req_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Datapath with slot table and output register.
  pss_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_now_ms_i     (in_req.now_ms),
    .req_rate_i       (in_req.rate_per_second),
    .rsp_valid_o      (out_rsp.valid),
    .rsp_ready_i      (out_rsp.ready),
    .rsp_kind_o       (out_rsp.kind),
    .rsp_slot_index_o (out_rsp.slot_index),
    .rsp_table_full_o (out_rsp.table_full),
    .rsp_last_o       (out_rsp.last)
  );

  assign in_req.ready = req_ready;

endmodule

@@ design/pss_div.sv @@
// Iterative restoring divider that computes RATE_NUMERATOR / rate, one quotient bit a cycle.
// Depends on pss_pkg.
module pss_div import pss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [PER_W-1:0]  quot_o
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [PER_W-1:0]  quo_r;
  logic [PER_W-1:0]  rem_r;
  logic [RATE_W-1:0] dvs_r;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[PER_W-1]};
  assign ge    = trial >= (PER_W + 1)'(dvs_r);
  assign diff  = trial - (PER_W + 1)'(dvs_r);

  // Control: busy for PER_W steps after a start, then done until the next start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(PER_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: the quotient register starts with the dividend and fills with quotient bits.
  // A zero rate is treated as a rate of one.
  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= PER_W'(RATE_NUMERATOR);
      rem_r <= '0;
      dvs_r <= (divisor_i == '0) ? RATE_W'(1) : divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[PER_W-2:0], ge};
      rem_r <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
    end
  end

  assign done_o = done_r;
  assign quot_o = quo_r;

endmodule

@@ design/pss_datapath.sv @@
// Slot table, walk index, pending fired result and output register of the scheduler.
// Depends on pss_pkg and instantiates pss_div.
module pss_datapath import pss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pss_cmd_t             cmd_i,
  output pss_sts_t             sts_o,
  input  logic [NOW_W-1:0]     req_now_ms_i,
  input  logic [RATE_W-1:0]    req_rate_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic [KIND_W-1:0]    rsp_kind_o,
  output logic [OUT_IDX_W-1:0] rsp_slot_index_o,
  output logic                 rsp_table_full_o,
  output logic                 rsp_last_o
);

  logic [NOW_W-1:0]     now_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SLOTS-1:0]     active_r;
  logic [NOW_W-1:0]     due_mem [SLOTS];
  logic [PER_W-1:0]     per_mem [SLOTS];
  logic [NOW_W-1:0]     due_q_r;
  logic [PER_W-1:0]     per_q_r;
  logic                 pend_valid_r;
  logic [IDX_W-1:0]     pend_idx_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic                 out_full_r;
  logic                 out_last_r;
  logic                 div_done;
  logic [PER_W-1:0]     div_quot;
  logic                 out_free;
  logic                 due_we;
  logic [NOW_W-1:0]     due_wdata;

  // Period divider, started together with the add request.
  pss_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (cmd_i.div_start),
    .divisor_i (req_rate_i),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      now_r <= req_now_ms_i;
    end
  end

  // Walk index over the slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_r <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Active bits: a slot becomes active when an add claims it and stays active.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cmd_i.add_wr) begin
      active_r[idx_r] <= 1'b1;
    end
  end

  // Due time memory: written on add (now) or on firing (now plus period).
  assign due_we    = cmd_i.add_wr || cmd_i.fire_wr;
  assign due_wdata = cmd_i.add_wr ? now_r : now_r + NOW_W'(per_q_r);

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[idx_r] <= due_wdata;
    end
    if (cmd_i.add_wr) begin
      per_mem[idx_r] <= div_quot;
    end
  end

  // Registered read of the slot under the walk index.
  always_ff @(posedge clk) begin
    if (cmd_i.mem_rd) begin
      due_q_r <= due_mem[idx_r];
      per_q_r <= per_mem[idx_r];
    end
  end

  // Pending fired result and count of results taken this tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else if (cmd_i.pend_clr) begin
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else if (cmd_i.pend_cap) begin
      pend_valid_r <= 1'b1;
      cnt_r        <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.pend_cap) begin
      pend_idx_r <= idx_r;
    end
  end

  // Output register: loaded on emit, released when the sink takes the result.
  assign out_free = !out_valid_r || rsp_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        EMIT_ADD_OK: begin
          out_kind_r <= KIND_ADD;
          out_idx_r  <= OUT_IDX_W'(idx_r);
          out_full_r <= 1'b0;
        end
        EMIT_ADD_FULL: begin
          out_kind_r <= KIND_ADD;
          out_idx_r  <= '0;
          out_full_r <= 1'b1;
        end
        EMIT_PEND: begin
          out_kind_r <= KIND_FIRED;
          out_idx_r  <= OUT_IDX_W'(pend_idx_r);
          out_full_r <= 1'b0;
        end
        default: begin
          out_kind_r <= KIND_IDLE;
          out_idx_r  <= '0;
          out_full_r <= 1'b0;
        end
      endcase
      out_last_r <= cmd_i.emit_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.idx_last   = (idx_r == IDX_W'(SLOTS - 1));
    sts_o.slot_act   = active_r[idx_r];
    sts_o.slot_hit   = active_r[idx_r] && (now_r >= due_q_r);
    sts_o.div_done   = div_done;
    sts_o.out_free   = out_free;
    sts_o.pend_valid = pend_valid_r;
    sts_o.cap_ok     = (cnt_r < CNT_W'(MAX_RESULTS));
  end

  assign rsp_valid_o      = out_valid_r;
  assign rsp_kind_o       = out_kind_r;
  assign rsp_slot_index_o = out_idx_r;
  assign rsp_table_full_o = out_full_r;
  assign rsp_last_o       = out_last_r;

`ifndef SYNTHESIS
  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> out_free)
    else $error("result loaded while output register is occupied");

  // An add never overwrites a slot that is already active.
  a_add_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.add_wr |-> !active_r[idx_r])
    else $error("add claimed an active slot");

  // The period is only stored once the divider has finished.
  a_add_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.add_wr |-> div_done)
    else $error("period stored before division finished");

  // The per-tick result count never passes the limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pend_cap |-> (cnt_r < CNT_W'(MAX_RESULTS)))
    else $error("fired result captured past the result limit");
`endif

endmodule

@@ design/pss_ctrl.sv @@
// Controller state machine that sequences add and tick requests over the slot table.
// Depends on pss_pkg; drives the datapath through pss_cmd_t and reads pss_sts_t.
module pss_ctrl import pss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid_i,
  input  logic     req_opcode_i,
  output logic     req_ready_o,
  input  pss_sts_t sts_i,
  output pss_cmd_t cmd_o
);

  pss_state_t state_r;
  pss_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt       = state_r;
    cmd_o           = '0;
    cmd_o.emit_sel  = EMIT_IDLE;
    req_ready_o     = 1'b0;

    case (state_r)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          if (req_opcode_i == OP_ADD) begin
            cmd_o.div_start = 1'b1;
            state_nxt       = S_ADD_SCAN;
          end else begin
            cmd_o.pend_clr = 1'b1;
            state_nxt      = S_TICK_RD;
          end
        end
      end

      // Look for the lowest inactive slot while the divider runs.
      S_ADD_SCAN: begin
        if (!sts_i.slot_act) begin
          state_nxt = S_ADD_DIV;
        end else if (sts_i.idx_last) begin
          state_nxt = S_ADD_FULL;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end

      S_ADD_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.add_wr = 1'b1;
          state_nxt    = S_ADD_REPLY;
        end
      end

      S_ADD_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_ADD_OK;
          cmd_o.emit_last = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_ADD_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_ADD_FULL;
          cmd_o.emit_last = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_TICK_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_nxt    = S_TICK_CHK;
      end

      // A firing slot is rescheduled and held as the pending result; the
      // previous pending result goes out first, which needs a free output.
      S_TICK_CHK: begin
        if (!(sts_i.slot_hit && sts_i.cap_ok && sts_i.pend_valid && !sts_i.out_free)) begin
          if (sts_i.slot_hit) begin
            cmd_o.fire_wr = 1'b1;
            if (sts_i.cap_ok) begin
              cmd_o.pend_cap = 1'b1;
              if (sts_i.pend_valid) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = EMIT_PEND;
              end
            end
          end
          if (sts_i.idx_last) begin
            state_nxt = S_TICK_END;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_nxt     = S_TICK_RD;
          end
        end
      end

      // Close the tick with the last fired result or a nothing-fired result.
      S_TICK_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = sts_i.pend_valid ? EMIT_PEND : EMIT_IDLE;
          cmd_o.emit_last = 1'b1;
          cmd_o.pend_clr  = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ dv/periodic_slot_scheduler_tb.sv @@
// Self-checking testbench for the periodic slot scheduler: a directed opening, then random
// add and tick requests under changing idle patterns, checked against a local slot model.
// Depends on pss_pkg, pss_ifs and the periodic_slot_scheduler RTL.
module periodic_slot_scheduler_tb;
  import pss_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 125;
  localparam logic [NOW_W-1:0] NOW_MAX = '1;

  typedef struct packed {
    logic              op;
    logic [NOW_W-1:0]  now_ms;
    logic [RATE_W-1:0] rate;
  } sched_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_IDX_W-1:0] slot_idx;
    logic                 full;
    logic                 last;
  } sched_rsp_t;

  logic clk;
  logic rst_n;

  pss_in_if  req_ch ();
  pss_out_if rsp_ch ();

  periodic_slot_scheduler uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Requests waiting to be offered and results the slot model has predicted.
  sched_req_t pending_reqs [$];
  sched_rsp_t expected_rsps [$];
  sched_req_t next_req;

  // Slot model state.
  logic             slot_busy [SLOTS];
  logic [NOW_W-1:0] slot_due  [SLOTS];
  logic [PER_W-1:0] slot_per  [SLOTS];

  int unsigned      send_idle_pct;
  int unsigned      sink_stall_pct;
  int unsigned      mismatch_count;
  int unsigned      adds_queued;
  logic [NOW_W-1:0] stim_now_ms;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Known values on every input, empty slot table, then one reset pulse.
  initial begin
    rst_n                  = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.opcode          = OP_TICK;
    req_ch.now_ms          = '0;
    req_ch.rate_per_second = '0;
    rsp_ch.ready           = 1'b0;
    send_idle_pct          = 0;
    sink_stall_pct         = 0;
    mismatch_count         = 0;
    adds_queued            = 0;
    stim_now_ms            = '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s] = 1'b0;
      slot_due[s]  = '0;
      slot_per[s]  = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Works out the results of one accepted request and updates the slot model.
  function automatic void predict_schedule(logic op, logic [NOW_W-1:0] now_ms,
                                           logic [RATE_W-1:0] rate);
    sched_rsp_t       rsp;
    logic [SLOTS-1:0] fired;
    int               free_slot;
    int               last_fire;
    int               fire_count;
    int               divisor;
    int               i;
    rsp        = '0;
    fired      = '0;
    free_slot  = -1;
    last_fire  = -1;
    fire_count = 0;
    if (op == OP_ADD) begin
      // Claim the lowest free slot; a zero rate counts as one event per second.
      for (i = 0; i < SLOTS; i++)
        if (!slot_busy[i] && free_slot < 0) free_slot = i;
      rsp.kind = KIND_ADD;
      rsp.last = 1'b1;
      if (free_slot < 0) begin
        rsp.full = 1'b1;
      end else begin
        divisor             = (rate == '0) ? 1 : int'(rate);
        slot_per[free_slot] = PER_W'(RATE_NUMERATOR / divisor);
        slot_due[free_slot] = now_ms;
        slot_busy[free_slot] = 1'b1;
        rsp.slot_idx        = OUT_IDX_W'(free_slot);
      end
      expected_rsps.push_back(rsp);
    end else begin
      // Every due slot fires and moves on by its period, wrapping at 32 bits.
      for (i = 0; i < SLOTS; i++) begin
        if (slot_busy[i] && now_ms >= slot_due[i]) begin
          slot_due[i] = now_ms + slot_per[i];
          if (fire_count < MAX_RESULTS) begin
            fired[i]  = 1'b1;
            last_fire = i;
            fire_count++;
          end
        end
      end
      if (fire_count == 0) begin
        rsp.kind = KIND_IDLE;
        rsp.last = 1'b1;
        expected_rsps.push_back(rsp);
      end else begin
        for (i = 0; i < SLOTS; i++) begin
          if (fired[i]) begin
            rsp.kind     = KIND_FIRED;
            rsp.slot_idx = OUT_IDX_W'(i);
            rsp.last     = (i == last_fire);
            expected_rsps.push_back(rsp);
          end
        end
      end
    end
  endfunction

  // Compares one accepted result with the oldest prediction.
  function automatic void check_result();
    sched_rsp_t got;
    sched_rsp_t want;
    got.kind     = rsp_ch.kind;
    got.slot_idx = rsp_ch.slot_index;
    got.full     = rsp_ch.table_full;
    got.last     = rsp_ch.last;
    if (expected_rsps.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("unexpected result: kind %0d slot %0d full %0b last %0b",
                 got.kind, got.slot_idx, got.full, got.last);
    end else begin
      want = expected_rsps.pop_front();
      if (got.kind !== want.kind || got.slot_idx !== want.slot_idx ||
          got.full !== want.full || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result mismatch: expected kind %0d slot %0d full %0b last %0b, %s",
                   want.kind, want.slot_idx, want.full, want.last,
                   $sformatf("got kind %0d slot %0d full %0b last %0b",
                             got.kind, got.slot_idx, got.full, got.last));
      end
    end
  endfunction

  // Request driver: predicts each accepted request, then offers the next one or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        predict_schedule(req_ch.opcode, req_ch.now_ms, req_ch.rate_per_second);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req               = pending_reqs.pop_front();
          req_ch.valid           <= 1'b1;
          req_ch.opcode          <= next_req.op;
          req_ch.now_ms          <= next_req.now_ms;
          req_ch.rate_per_second <= next_req.rate;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        check_result();
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic queue_request(logic op, logic [NOW_W-1:0] now_ms, logic [RATE_W-1:0] rate);
    sched_req_t req;
    req.op     = op;
    req.now_ms = now_ms;
    req.rate   = rate;
    pending_reqs.push_back(req);
    if (op == OP_ADD) adds_queued++;
  endtask

  // Mostly adds at the running time and ticks moving forward; the rest are small steps
  // back in time and jumps to arbitrary times, which also cover the wraparound region.
  task automatic queue_random_request();
    int unsigned       pick;
    logic [RATE_W-1:0] rate;
    pick = $urandom_range(99);
    case ($urandom_range(4))
      0:       rate = RATE_W'($urandom_range(10, 1));
      1:       rate = RATE_W'($urandom_range(200, 11));
      2:       rate = RATE_W'($urandom_range(1000, 201));
      3:       rate = RATE_W'($urandom_range(1023, 1001));
      default: rate = RATE_W'($urandom_range(1023, 0));
    endcase
    if (pick < 20) begin
      queue_request(OP_ADD, stim_now_ms, rate);
    end else if (pick < 90) begin
      stim_now_ms = stim_now_ms + $urandom_range(300);
      queue_request(OP_TICK, stim_now_ms, rate);
    end else if (pick < 95) begin
      queue_request(OP_TICK, stim_now_ms - $urandom_range(2000), rate);
    end else begin
      stim_now_ms = $urandom();
      queue_request($urandom_range(1) ? OP_ADD : OP_TICK, stim_now_ms, rate);
    end
  endtask

  // Holds the sender back until every offered request has been answered in full.
  task automatic wait_for_quiet();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus sequence and final verdict.
  initial begin : stimulus
    int phase;
    wait (rst_n);
    @(negedge clk);

    // Directed opening: empty table, zero and extreme rates, wraparound of due times.
    queue_request(OP_TICK, 32'd0, 10'd0);
    queue_request(OP_ADD, 32'd100, 10'd0);
    queue_request(OP_ADD, 32'd100, 10'd1000);
    queue_request(OP_ADD, 32'd50, 10'd1023);
    queue_request(OP_ADD, NOW_MAX, 10'd1);
    queue_request(OP_ADD, 32'd100, 10'd1001);
    queue_request(OP_TICK, 32'd99, 10'd0);
    queue_request(OP_TICK, 32'd100, 10'd1023);
    queue_request(OP_TICK, 32'd100, 10'd0);
    queue_request(OP_TICK, NOW_MAX, 10'd0);
    queue_request(OP_TICK, 32'd0, 10'd0);
    queue_request(OP_TICK, 32'd999, 10'd0);
    queue_request(OP_ADD, 32'd999, 10'd512);
    queue_request(OP_ADD, 32'd999, 10'd3);
    queue_request(OP_ADD, 32'd999, 10'd999);
    queue_request(OP_TICK, 32'd5000, 10'd0);
    queue_request(OP_TICK, 32'd1000, 10'd0);
    queue_request(OP_ADD, 32'h5555_5555, 10'h2AA);
    queue_request(OP_ADD, 32'hAAAA_AAAA, 10'h155);
    queue_request(OP_TICK, 32'hAAAA_AAAA, 10'h3FF);
    stim_now_ms = 32'd5000;
    wait_for_quiet();

    // Random phases: free flow, sender gaps, receiver stalls, then both at once.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 57; end
        default: begin send_idle_pct = 18; sink_stall_pct = 18; end
      endcase
      // Make sure the table has been filled and overflowed before the last phases.
      if (phase == 2)
        while (adds_queued <= SLOTS + 1) queue_request(OP_ADD, stim_now_ms, 10'd25);
      repeat (PHASE_ITEMS) queue_random_request();
      wait_for_quiet();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_rsps.size() == 0)
      $display("PASS periodic_slot_scheduler");
    else
      $display("FAIL periodic_slot_scheduler");
    $finish;
  end

  // Timeout guard.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL periodic_slot_scheduler");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pss_pkg.sv
design/pss_ifs.sv
design/pss_div.sv
design/pss_datapath.sv
design/pss_ctrl.sv
design/periodic_slot_scheduler.sv
dv/periodic_slot_scheduler_tb.sv
